// ===== rtl/core/ist_pkg.sv =====
// Package: shared types, constants and controller encodings for the interval set table.
package ist_pkg;

    localparam int MaxRanges = 64;
    localparam int NumWidth  = 32;
    localparam int IdxWidth  = $clog2(MaxRanges);
    localparam int CntWidth  = $clog2(MaxRanges + 1);

    localparam logic CmdInsert = 1'b0;
    localparam logic CmdRemove = 1'b1;

    typedef logic [NumWidth-1:0] num_t;
    typedef logic [IdxWidth-1:0] idx_t;
    typedef logic [CntWidth-1:0] cnt_t;

    typedef struct packed {
        logic cmd;
        num_t low_value;
        num_t high_value;
    } in_beat_t;

    typedef struct packed {
        logic did_change;
        logic ever_changed;
        cnt_t range_count;
        logic status;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLAN,
        ST_COPY,
        ST_DONE
    } ctl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input beat, clear walk state
        logic scan;     // one read/classify step of the walk
        logic plan;     // decide operation after the walk
        logic copy;     // one write-back step
        logic finish;   // latch result beat
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
        logic copy_last;
        logic no_copy;
    } dp_stat_t;

endpackage

// ===== rtl/core/ist_ctrl.sv =====
// Controller: sequences load, table walk, planning, write-back and result.
module ist_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic             out_free,
    input  ist_pkg::dp_stat_t stat,
    output ist_pkg::dp_cmd_t cmd,
    output logic             busy
);
    import ist_pkg::*;

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_SCAN;
            ST_SCAN: if (stat.scan_last) state_next = ST_PLAN;
            ST_PLAN: state_next = stat.no_copy ? ST_DONE : ST_COPY;
            ST_COPY: if (stat.copy_last) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE: begin busy = 1'b0; cmd.load = in_fire; end
            ST_SCAN: cmd.scan = 1'b1;
            ST_PLAN: cmd.plan = 1'b1;
            ST_COPY: cmd.copy = 1'b1;
            ST_DONE: cmd.finish = out_free;
            default: busy = 1'b1;
        endcase
    end

    a_scan_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_SCAN)
        else $error("load did not start walk");
    a_copy_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY) |-> ($past(state_reg) == ST_PLAN || $past(state_reg) == ST_COPY))
        else $error("copy entered out of order");
    a_onehot_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("multiple datapath commands");

endmodule

// ===== rtl/core/ist_dpath.sv =====
// Datapath: range tables, walk logic, scratch table and result formation.
module ist_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  ist_pkg::in_beat_t   in_beat,
    input  ist_pkg::dp_cmd_t    cmd,
    output ist_pkg::dp_stat_t   stat,
    output ist_pkg::out_beat_t  result,
    output logic                result_set
);
    import ist_pkg::*;

    // main table and scratch (remove output) table
    num_t lo_mem [MaxRanges];
    num_t hi_mem [MaxRanges];
    num_t slo_mem [MaxRanges];
    num_t shi_mem [MaxRanges];

    localparam int WalkW = CntWidth + 1;
    localparam num_t NumMax = '1;

    in_beat_t op_reg;
    cnt_t     total_reg, total_next;
    logic     ever_reg;
    logic [WalkW-1:0] rd_reg;      // read index of walk (one ahead of data)
    logic [WalkW-1:0] k_reg;       // index of entry present in rdata
    logic     rvalid_reg;
    num_t     ra_reg, rb_reg;      // registered read data
    // insert bookkeeping
    cnt_t     pos_reg;
    logic     pos_found_reg;
    logic     covered_reg;
    logic     up_reg, down_reg;
    num_t     prev_hi_reg;         // high end of entry pos-1
    num_t     pos_hi_reg;          // high end of entry pos
    // remove bookkeeping
    logic [WalkW-1:0] cnt_reg;     // scratch fill count (may reach MaxRanges+1)
    logic     hit_reg;
    // write-back
    logic [1:0] mode_reg;          // 0 none,1 insert-new,2 merge,3 remove copy
    logic [WalkW-1:0] wk_reg;
    num_t     wbuf_lo_reg, wbuf_hi_reg;
    logic     chg_reg, stat_reg;
    num_t     sr_lo_reg, sr_hi_reg;
    logic     sr_v_reg;

    localparam logic [1:0] ModeNone  = 2'd0;
    localparam logic [1:0] ModeNew   = 2'd1;
    localparam logic [1:0] ModeMerge = 2'd2;
    localparam logic [1:0] ModeCopy  = 2'd3;

    logic [WalkW-1:0] tot_w;
    assign tot_w = WalkW'(total_reg);

    logic scan_done;
    assign scan_done = rvalid_reg ? (k_reg + 1'b1 >= tot_w) : (tot_w == '0);
    assign stat.scan_last = cmd.scan && scan_done;

    // scratch slot writes during remove walk
    logic lv_gt_hv;
    assign lv_gt_hv = op_reg.low_value > op_reg.high_value;
    logic miss, keep_a, keep_b;
    assign miss   = (ra_reg > op_reg.high_value) || (rb_reg < op_reg.low_value);
    assign keep_a = ra_reg < op_reg.low_value;
    assign keep_b = rb_reg > op_reg.high_value;

    always_ff @(posedge clk)
    begin
        if (cmd.scan && rvalid_reg && op_reg.cmd == CmdRemove) begin
            if (miss) begin
                if (cnt_reg < WalkW'(MaxRanges)) begin
                    slo_mem[cnt_reg[IdxWidth-1:0]] <= ra_reg;
                    shi_mem[cnt_reg[IdxWidth-1:0]] <= rb_reg;
                end
            end else begin
                if (keep_a && cnt_reg < WalkW'(MaxRanges)) begin
                    slo_mem[cnt_reg[IdxWidth-1:0]] <= ra_reg;
                    shi_mem[cnt_reg[IdxWidth-1:0]] <= op_reg.low_value - 1'b1;
                end
                if (keep_b) begin
                    if (keep_a && cnt_reg + 1'b1 < WalkW'(MaxRanges)) begin
                        slo_mem[IdxWidth'(cnt_reg + 1'b1)] <= op_reg.high_value + 1'b1;
                        shi_mem[IdxWidth'(cnt_reg + 1'b1)] <= rb_reg;
                    end else if (!keep_a && cnt_reg < WalkW'(MaxRanges)) begin
                        slo_mem[cnt_reg[IdxWidth-1:0]] <= op_reg.high_value + 1'b1;
                        shi_mem[cnt_reg[IdxWidth-1:0]] <= rb_reg;
                    end
                end
            end
        end
    end

    // planning decision
    logic [1:0] plan_mode;
    logic       plan_chg, plan_stat;
    cnt_t       plan_total;
    logic       plan_up, plan_down;
    assign plan_up   = pos_found_reg && !covered_reg && up_reg;
    assign plan_down = (pos_reg != '0) && (op_reg.low_value != '0)
                       && (prev_hi_reg == op_reg.low_value - 1'b1);

    always_comb
    begin
        plan_mode = ModeNone;
        plan_chg = 1'b0;
        plan_stat = 1'b0;
        plan_total = total_reg;
        if (op_reg.cmd == CmdInsert) begin
            if (!covered_reg) begin
                plan_chg = 1'b1;
                if (plan_up && plan_down) begin
                    plan_mode = ModeMerge;
                    plan_total = total_reg - 1'b1;
                end else if (plan_up || plan_down) begin
                    plan_mode = ModeNone;
                end else if (total_reg >= CntWidth'(MaxRanges)) begin
                    plan_chg = 1'b0;
                    plan_stat = 1'b1;
                end else begin
                    plan_mode = ModeNew;
                    plan_total = total_reg + 1'b1;
                end
            end
        end else if (!lv_gt_hv && hit_reg) begin
            if (cnt_reg > WalkW'(MaxRanges)) begin
                plan_stat = 1'b1;
            end else begin
                plan_chg = 1'b1;
                plan_total = CntWidth'(cnt_reg);
                plan_mode = (cnt_reg == '0) ? ModeNone : ModeCopy;
            end
        end
    end
    assign stat.no_copy = (plan_mode == ModeNone);

    // main table: one read port (walk / shift source), one write port
    logic [WalkW-1:0] raddr;
    logic do_read, we_lo, we_hi;
    idx_t waddr;
    num_t wlo, whi;

    always_comb
    begin
        raddr = rd_reg;
        do_read = cmd.scan && (rd_reg < tot_w);
        we_lo = 1'b0;
        we_hi = 1'b0;
        waddr = '0;
        wlo = '0;
        whi = '0;
        // endpoint edits for insert without shifting
        if (cmd.plan && op_reg.cmd == CmdInsert && !covered_reg) begin
            if (plan_up && plan_down) begin
                we_hi = 1'b1;
                waddr = IdxWidth'(pos_reg - 1'b1);
                whi = pos_hi_reg;
            end else if (plan_up) begin
                we_lo = 1'b1;
                waddr = IdxWidth'(pos_reg);
                wlo = op_reg.low_value;
            end else if (plan_down) begin
                we_hi = 1'b1;
                waddr = IdxWidth'(pos_reg - 1'b1);
                whi = op_reg.low_value;
            end
        end
        if (cmd.copy) begin
            case (mode_reg)
                ModeNew: begin
                    // shift up from the top: entry wk -> wk+1, finish with new entry
                    raddr = wk_reg - 1'b1;
                    do_read = 1'b1;
                    we_lo = sr_v_reg;
                    we_hi = sr_v_reg;
                    waddr = IdxWidth'(wk_reg + 1'b1);
                    wlo = sr_lo_reg;
                    whi = sr_hi_reg;
                    if (wk_reg + 1'b1 == WalkW'(pos_reg)) begin
                        we_lo = 1'b1;
                        we_hi = 1'b1;
                        waddr = IdxWidth'(pos_reg);
                        wlo = op_reg.low_value;
                        whi = op_reg.low_value;
                    end
                end
                ModeMerge: begin
                    // shift down: entry wk -> wk-1
                    raddr = wk_reg + 1'b1;
                    do_read = 1'b1;
                    we_lo = sr_v_reg;
                    we_hi = sr_v_reg;
                    waddr = IdxWidth'(wk_reg - 1'b1);
                    wlo = sr_lo_reg;
                    whi = sr_hi_reg;
                end
                ModeCopy: begin
                    we_lo = 1'b1;
                    we_hi = 1'b1;
                    waddr = IdxWidth'(wk_reg);
                    wlo = wbuf_lo_reg;
                    whi = wbuf_hi_reg;
                end
                default: we_lo = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_read) begin
            ra_reg <= lo_mem[raddr[IdxWidth-1:0]];
            rb_reg <= hi_mem[raddr[IdxWidth-1:0]];
        end
        if (we_lo)
            lo_mem[waddr] <= wlo;
        if (we_hi)
            hi_mem[waddr] <= whi;
    end

    // scratch read for copy mode
    always_ff @(posedge clk)
    begin
        if (cmd.plan || (cmd.copy && mode_reg == ModeCopy)) begin
            wbuf_lo_reg <= slo_mem[cmd.plan ? '0 : IdxWidth'(wk_reg + 1'b1)];
            wbuf_hi_reg <= shi_mem[cmd.plan ? '0 : IdxWidth'(wk_reg + 1'b1)];
        end
    end

    // copy-phase end
    logic copy_last;
    always_comb
    begin
        case (mode_reg)
            ModeNew:   copy_last = (wk_reg + 1'b1 == WalkW'(pos_reg));
            ModeMerge: copy_last = (wk_reg >= tot_w);
            ModeCopy:  copy_last = (wk_reg + 1'b1 >= cnt_reg);
            default:   copy_last = 1'b1;
        endcase
    end
    assign stat.copy_last = copy_last;

    // control and bookkeeping registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            total_reg  <= '0;
            ever_reg   <= 1'b0;
            rvalid_reg <= 1'b0;
            result_set <= 1'b0;
        end else begin
            total_reg <= total_next;
            if (cmd.load)
                result_set <= 1'b0;
            if (cmd.scan)
                rvalid_reg <= do_read;
            else
                rvalid_reg <= 1'b0;
            if (cmd.finish) begin
                result_set <= 1'b1;
                ever_reg   <= ever_reg | chg_reg;
            end
        end
    end
    assign total_next = cmd.plan ? plan_total : total_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            op_reg        <= in_beat;
            rd_reg        <= '0;
            k_reg         <= '0;
            pos_reg       <= '0;
            pos_found_reg <= 1'b0;
            covered_reg   <= 1'b0;
            up_reg        <= 1'b0;
            prev_hi_reg   <= '0;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
        end
        if (cmd.scan) begin
            if (do_read)
                rd_reg <= rd_reg + 1'b1;
            if (rvalid_reg) begin
                k_reg <= rd_reg;
                if (op_reg.cmd == CmdInsert) begin
                    if (!pos_found_reg) begin
                        if (rb_reg < op_reg.low_value) begin
                            pos_reg     <= pos_reg + 1'b1;
                            prev_hi_reg <= rb_reg;
                        end else begin
                            pos_found_reg <= 1'b1;
                            pos_hi_reg    <= rb_reg;
                            covered_reg   <= ra_reg <= op_reg.low_value;
                            up_reg        <= (op_reg.low_value != NumMax)
                                             && (ra_reg == op_reg.low_value + 1'b1);
                        end
                    end
                end else if (!lv_gt_hv) begin
                    if (miss) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end else begin
                        hit_reg <= 1'b1;
                        cnt_reg <= cnt_reg + WalkW'(keep_a) + WalkW'(keep_b);
                    end
                end
            end
        end
        if (cmd.plan) begin
            mode_reg  <= plan_mode;
            chg_reg   <= plan_chg;
            stat_reg  <= plan_stat;
            sr_v_reg  <= 1'b0;
            case (plan_mode)
                ModeNew:   wk_reg <= tot_w;
                ModeMerge: wk_reg <= WalkW'(pos_reg);
                default:   wk_reg <= '0;
            endcase
        end
        if (cmd.copy) begin
            case (mode_reg)
                ModeNew: begin
                    sr_v_reg <= 1'b1;
                    wk_reg   <= wk_reg - 1'b1;
                end
                ModeMerge: begin
                    sr_v_reg <= 1'b1;
                    wk_reg   <= wk_reg + 1'b1;
                end
                default: wk_reg <= wk_reg + 1'b1;
            endcase
            sr_lo_reg <= lo_mem[raddr[IdxWidth-1:0]];
            sr_hi_reg <= hi_mem[raddr[IdxWidth-1:0]];
        end
    end

    assign result.did_change   = chg_reg;
    assign result.ever_changed = ever_reg;
    assign result.range_count  = total_reg;
    assign result.status       = stat_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CntWidth'(MaxRanges))
        else $error("range count beyond table depth");
    a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(chg_reg && stat_reg))
        else $error("changed and full flagged together");
    a_ever_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(ever_reg) |-> ever_reg)
        else $error("sticky change flag cleared");

endmodule

// ===== rtl/core/interval_set_table.sv =====
// Top level: interval set table with valid/ready input and output channels.
//
//   channel | dir | handshake       | beat type
//   --------+-----+-----------------+---------------------
//   in      | in  | in_valid/ready  | ist_pkg::in_beat_t
//   out     | out | out_valid/ready | ist_pkg::out_beat_t
//
// One operation at a time: accept step, walk of all held ranges, a plan
// step, then a write-back walk (shift for a new or merged range, copy of the
// rebuilt table for a remove) and a finish step; the single table port
// serialises the walks. Reset empties the table at once; stored ends need no
// clearing. The output register holds the result beat while out_ready is
// low; finish waits for that register to free, and the next input beat is
// taken once the result has moved into it.
module interval_set_table (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ist_pkg::in_beat_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ist_pkg::out_beat_t  out_data
);
    import ist_pkg::*;

    dp_cmd_t   cmd;
    dp_stat_t  stat;
    out_beat_t result;
    logic      result_set;
    logic      busy;
    logic      out_valid_reg;
    logic      out_free;

    // hold the finished beat until taken
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !busy;

    ist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_valid && in_ready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    ist_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_beat    (in_data),
        .cmd        (cmd),
        .stat       (stat),
        .result     (result),
        .result_set (result_set)
    );

    // output register: advance a new beat on finish, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish) begin
            out_data.did_change   <= result.did_change;
            out_data.ever_changed <= result.ever_changed | result.did_change;
            out_data.range_count  <= result.range_count;
            out_data.status       <= result.status;
        end
    end

    assign out_valid = out_valid_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_data))
        else $error("output beat dropped while stalled");
    a_finish_after_set: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> result_set)
        else $error("result not marked after finish");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second beat taken during operation");

endmodule

// ===== dv/interval_set_table_tb.sv =====
// Testbench for the interval set table: a self-checking run of insert and remove beats.
`timescale 1ns / 1ps

module interval_set_table_tb;
    import ist_pkg::*;

    localparam int unsigned NumTop     = 32'hFFFF_FFFF;
    localparam int          StallLimit = 20000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_beat_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_beat_t  out_data;

    interval_set_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Predicted table: sorted, disjoint, inclusive ranges.
    num_t       tbl_lo[$];
    num_t       tbl_hi[$];
    logic       seen_change;
    out_beat_t  pending_results[$];

    int         fail_count;
    int         result_count;
    int         idle_cycles;
    int         inserts_sent;
    int         removes_sent;
    int         full_hits;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Apply one insert to the predicted table and return the expected beat.
    function automatic out_beat_t predict_insert(num_t n);
        out_beat_t r;
        int        pos;
        bit        up;
        bit        down;
        r = '0;
        pos = 0;
        while (pos < tbl_lo.size() && tbl_hi[pos] < n)
            pos++;
        if (!(pos < tbl_lo.size() && tbl_lo[pos] <= n))
        begin
            up   = pos < tbl_lo.size() && n != NumTop && tbl_lo[pos] == n + 1;
            down = pos > 0 && n != 0 && tbl_hi[pos-1] == n - 1;
            if (up && down)
            begin
                tbl_hi[pos-1] = tbl_hi[pos];
                tbl_lo.delete(pos);
                tbl_hi.delete(pos);
                r.did_change = 1'b1;
            end
            else if (up)
            begin
                tbl_lo[pos] = n;
                r.did_change = 1'b1;
            end
            else if (down)
            begin
                tbl_hi[pos-1] = n;
                r.did_change = 1'b1;
            end
            else if (tbl_lo.size() >= MaxRanges)
                r.status = 1'b1;
            else
            begin
                tbl_lo.insert(pos, n);
                tbl_hi.insert(pos, n);
                r.did_change = 1'b1;
            end
        end
        return r;
    endfunction

    // Remove an inclusive span; rebuild the table, reject it on overflow.
    function automatic out_beat_t predict_remove(num_t l, num_t h);
        out_beat_t r;
        num_t      new_lo[$];
        num_t      new_hi[$];
        bit        hit;
        r = '0;
        hit = 0;
        if (l <= h)
        begin
            foreach (tbl_lo[k])
            begin
                if (tbl_lo[k] > h || tbl_hi[k] < l)
                begin
                    new_lo.push_back(tbl_lo[k]);
                    new_hi.push_back(tbl_hi[k]);
                    continue;
                end
                hit = 1;
                if (tbl_lo[k] < l)
                begin
                    new_lo.push_back(tbl_lo[k]);
                    new_hi.push_back(l - 1);
                end
                if (tbl_hi[k] > h)
                begin
                    new_lo.push_back(h + 1);
                    new_hi.push_back(tbl_hi[k]);
                end
            end
            if (hit)
            begin
                if (new_lo.size() > MaxRanges)
                    r.status = 1'b1;
                else
                begin
                    tbl_lo = new_lo;
                    tbl_hi = new_hi;
                    r.did_change = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Drive one beat, hold it until accepted, then log its expected result.
    task automatic send_op(logic cmd, num_t lv, num_t hv);
        out_beat_t exp_beat;
        int        gap;
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= '{cmd: cmd, low_value: lv, high_value: hv};
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (cmd == CmdInsert)
        begin
            exp_beat = predict_insert(lv);
            inserts_sent++;
        end
        else
        begin
            exp_beat = predict_remove(lv, hv);
            removes_sent++;
        end
        if (exp_beat.did_change)
            seen_change = 1'b1;
        if (exp_beat.status)
            full_hits++;
        exp_beat.ever_changed = seen_change;
        exp_beat.range_count  = cnt_t'(tbl_lo.size());
        pending_results.push_back(exp_beat);
        @(negedge clk);
    endtask

    task automatic run_directed_edges();
        send_op(CmdRemove, 0, NumTop);        // remove on empty table
        send_op(CmdInsert, 0, 0);             // low end of number space
        send_op(CmdInsert, NumTop, 0);        // high end of number space
        send_op(CmdInsert, NumTop - 1, 0);    // extend downward
        send_op(CmdInsert, 1, 0);             // extend upward
        send_op(CmdInsert, 1, 5);             // already covered
        send_op(CmdInsert, 3, 0);
        send_op(CmdInsert, 2, 0);             // merge two neighbors
        send_op(CmdRemove, 9, 4);             // empty span, low above high
        send_op(CmdRemove, 100, 200);         // touches nothing
        send_op(CmdRemove, 2, 2);             // split through the middle
        send_op(CmdRemove, 0, 0);             // trim low end
        send_op(CmdRemove, NumTop, NumTop);   // trim high end
        send_op(CmdRemove, 0, NumTop);        // drop everything
    endtask

    // Fill all entries, then hit the full-table cases for insert and split.
    task automatic run_full_table();
        for (int i = 0; i < MaxRanges; i++)
            send_op(CmdInsert, num_t'(i * 4 + 10), 0);
        send_op(CmdInsert, 500, 0);           // new range in full table
        send_op(CmdInsert, 11, 0);            // extend still allowed
        send_op(CmdInsert, 12, 0);
        send_op(CmdInsert, 13, 0);            // merge frees an entry
        send_op(CmdInsert, 700, 0);           // fills the freed entry
        send_op(CmdRemove, 10, 10);           // trim in full table
        send_op(CmdInsert, 1000, 0);
        send_op(CmdRemove, 12, 12);           // split in full table
        send_op(CmdRemove, 0, NumTop);
    endtask

    // Mostly clustered numbers so ranges grow, touch and merge.
    task automatic run_random_mix(int count);
        num_t base;
        num_t lv;
        num_t hv;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0: base = $urandom();
                1: base = NumTop - 200;
                default: base = 32'h8000_0000;
            endcase
            if (base == NumTop - 200 || base == 32'h8000_0000)
                lv = base + $urandom_range(0, 200);
            else
                lv = base;
            if ($urandom_range(0, 9) == 0)
                lv = $urandom_range(0, 150);
            if ($urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    hv = $urandom();
                else
                    hv = lv + $urandom_range(0, 6) - ($urandom_range(0, 7) == 0 ? 8 : 0);
                send_op(CmdRemove, lv, hv);
            end
            else
                send_op(CmdInsert, lv, $urandom());
            if (tbl_lo.size() > 56 && $urandom_range(0, 3) == 0)
                send_op(CmdRemove, 0, NumTop);
        end
    endtask

    // Check each result beat against the oldest expectation.
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            result_count <= result_count + 1;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: %p", out_data);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.did_change !== want.did_change)
                begin
                    $error("did_change expected %0d actual %0d",
                           want.did_change, out_data.did_change);
                    fail_count++;
                end
                if (out_data.ever_changed !== want.ever_changed)
                begin
                    $error("ever_changed expected %0d actual %0d",
                           want.ever_changed, out_data.ever_changed);
                    fail_count++;
                end
                if (out_data.range_count !== want.range_count)
                begin
                    $error("range_count expected %0d actual %0d",
                           want.range_count, out_data.range_count);
                    fail_count++;
                end
                if (out_data.status !== want.status)
                begin
                    $error("status expected %0d actual %0d",
                           want.status, out_data.status);
                    fail_count++;
                end
            end
        end
    end

    // Stall the result side at random, with runs of no stall.
    initial
    begin
        int hold;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (hold != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // Watchdog: count cycles without any accepted beat.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= StallLimit)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        in_valid     = 1'b0;
        in_data      = '0;
        rst_n        = 1'b0;
        seen_change  = 1'b0;
        fail_count   = 0;
        result_count = 0;
        inserts_sent = 0;
        removes_sent = 0;
        full_hits    = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed_edges();
        run_full_table();
        run_random_mix(1600);
        in_valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (200) @(posedge clk);
        $display("covered %0d inserts and %0d removes, %0d full-table rejects",
                 inserts_sent, removes_sent, full_hits);
        $display("checked %0d result beats", result_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ist_pkg.sv
rtl/core/ist_ctrl.sv
rtl/core/ist_dpath.sv
rtl/core/interval_set_table.sv
dv/interval_set_table_tb.sv
